### sv/swm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swm_pkg: shared definitions for the sliding window median filter
// Window size, sample widths, controller states and the command and status
// structures that join the controller to the datapath.
// ----------------------------------------------------------------------------
package swm_pkg;

   localparam int WINDOW      = 64;
   localparam int SAMPLE_BITS = 16;

   localparam int SAMPLE_W = 16;
   localparam int SUM_W    = 17;
   localparam int IDX_BITS = $clog2(WINDOW);
   localparam int CNT_BITS = $clog2(WINDOW + 1);

   localparam int HALF_LO = WINDOW / 2 - 1;
   localparam int HALF_HI = WINDOW / 2;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
      SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_MED_LO,
      S_MED_HI,
      S_MED_END,
      S_REMOVE,
      S_INS_RD,
      S_INS_CMP,
      S_FINISH,
      S_EMIT
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_TAKE,
      OP_MED_LO,
      OP_MED_HI,
      OP_MED_END,
      OP_REMOVE,
      OP_INS_RD,
      OP_INS_CMP,
      OP_FINISH,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic scan_done;
      logic pos_zero;
      logic pos_one;
      logic ins_gt;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

### sv/swm_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swm_ram: generic simple dual port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module swm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

### sv/swm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swm_ctrl: sequencing controller for the median filter
// Steps one sample through median read, removal pass, insertion and output.
// ----------------------------------------------------------------------------
module swm_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire swm_pkg::status_type status,
   output swm_pkg::cmd_type        cmd
);

   swm_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= swm_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.op    = swm_pkg::OP_NONE;
      req_stall = (state_ff != swm_pkg::S_IDLE);
      unique case (state_ff)
         swm_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.op   = swm_pkg::OP_TAKE;
               state_in = status.full ? swm_pkg::S_MED_LO : swm_pkg::S_INS_RD;
            end
         end
         swm_pkg::S_MED_LO: begin
            cmd.op   = swm_pkg::OP_MED_LO;
            state_in = swm_pkg::S_MED_HI;
         end
         swm_pkg::S_MED_HI: begin
            cmd.op   = swm_pkg::OP_MED_HI;
            state_in = swm_pkg::S_MED_END;
         end
         swm_pkg::S_MED_END: begin
            cmd.op   = swm_pkg::OP_MED_END;
            state_in = swm_pkg::S_REMOVE;
         end
         swm_pkg::S_REMOVE: begin
            cmd.op = swm_pkg::OP_REMOVE;
            if (status.scan_done) begin
               state_in = swm_pkg::S_INS_RD;
            end
         end
         swm_pkg::S_INS_RD: begin
            cmd.op   = swm_pkg::OP_INS_RD;
            state_in = status.pos_zero ? swm_pkg::S_FINISH : swm_pkg::S_INS_CMP;
         end
         swm_pkg::S_INS_CMP: begin
            cmd.op = swm_pkg::OP_INS_CMP;
            if (!status.ins_gt) begin
               state_in = swm_pkg::S_FINISH;
            end else if (status.pos_one) begin
               state_in = swm_pkg::S_INS_RD;
            end
         end
         swm_pkg::S_FINISH: begin
            cmd.op   = swm_pkg::OP_FINISH;
            state_in = status.full ? swm_pkg::S_EMIT : swm_pkg::S_IDLE;
         end
         swm_pkg::S_EMIT: begin
            if (status.out_free) begin
               cmd.op   = swm_pkg::OP_EMIT;
               state_in = swm_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = swm_pkg::S_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

### sv/swm_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swm_dp: datapath of the median filter
// Holds the sample ring and the sorted window in RAMs, the fill count, the
// ring pointer, the scan counters and the output register.
// ----------------------------------------------------------------------------
module swm_dp (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [swm_pkg::SAMPLE_W-1:0]   req_sample,
   input  wire swm_pkg::cmd_type               cmd,
   output swm_pkg::status_type                 status,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic      [swm_pkg::SAMPLE_W-1:0]   rsp_lower_middle,
   output logic      [swm_pkg::SAMPLE_W-1:0]   rsp_upper_middle,
   output logic      [swm_pkg::SUM_W-1:0]      rsp_middle_sum
);

   logic [swm_pkg::SAMPLE_W-1:0] sample_ff, sample_in;
   logic [swm_pkg::SAMPLE_W-1:0] oldest_ff, oldest_in;
   logic [swm_pkg::SAMPLE_W-1:0] lo_ff, lo_in;
   logic [swm_pkg::SAMPLE_W-1:0] hi_ff, hi_in;
   logic                         found_ff, found_in;
   logic [swm_pkg::CNT_BITS-1:0] scan_ff, scan_in;
   logic [swm_pkg::CNT_BITS-1:0] pos_ff, pos_in;
   logic [swm_pkg::CNT_BITS-1:0] fill_ff, fill_in;
   logic [swm_pkg::IDX_BITS-1:0] ptr_ff, ptr_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [swm_pkg::SAMPLE_W-1:0] rsp_lo_ff, rsp_lo_in;
   logic [swm_pkg::SAMPLE_W-1:0] rsp_hi_ff, rsp_hi_in;
   logic [swm_pkg::SUM_W-1:0]    rsp_sum_ff, rsp_sum_in;

   logic                         srt_we;
   logic [swm_pkg::IDX_BITS-1:0] srt_waddr, srt_raddr;
   logic [swm_pkg::SAMPLE_W-1:0] srt_wdata, srt_rdata;
   logic                         ring_we;
   logic [swm_pkg::IDX_BITS-1:0] ring_waddr, ring_raddr;
   logic [swm_pkg::SAMPLE_W-1:0] ring_wdata, ring_rdata;

   logic [swm_pkg::CNT_BITS-1:0] scan_m2, pos_m1, pos_m2;
   logic                         full;

   swm_ram #(.WIDTH(swm_pkg::SAMPLE_W), .DEPTH(swm_pkg::WINDOW)) u_sorted (
      .clock   (clock),
      .wr_en   (srt_we),
      .wr_addr (srt_waddr),
      .wr_data (srt_wdata),
      .rd_addr (srt_raddr),
      .rd_data (srt_rdata)
   );

   swm_ram #(.WIDTH(swm_pkg::SAMPLE_W), .DEPTH(swm_pkg::WINDOW)) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (ring_waddr),
      .wr_data (ring_wdata),
      .rd_addr (ring_raddr),
      .rd_data (ring_rdata)
   );

   assign full    = (fill_ff == swm_pkg::CNT_BITS'(swm_pkg::WINDOW));
   assign scan_m2 = scan_ff - swm_pkg::CNT_BITS'(2);
   assign pos_m1  = pos_ff - swm_pkg::CNT_BITS'(1);
   assign pos_m2  = pos_ff - swm_pkg::CNT_BITS'(2);

   assign status.full      = full;
   assign status.scan_done = (scan_ff == swm_pkg::CNT_BITS'(swm_pkg::WINDOW));
   assign status.pos_zero  = (pos_ff == '0);
   assign status.pos_one   = (pos_ff == swm_pkg::CNT_BITS'(1));
   assign status.ins_gt    = (srt_rdata > sample_ff);
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         ptr_ff       <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         ptr_ff       <= ptr_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff  <= sample_in;
      oldest_ff  <= oldest_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      scan_ff    <= scan_in;
      pos_ff     <= pos_in;
      rsp_lo_ff  <= rsp_lo_in;
      rsp_hi_ff  <= rsp_hi_in;
      rsp_sum_ff <= rsp_sum_in;
   end

   always_comb begin
      sample_in    = sample_ff;
      oldest_in    = oldest_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      found_in     = found_ff;
      scan_in      = scan_ff;
      pos_in       = pos_ff;
      fill_in      = fill_ff;
      ptr_in       = ptr_ff;
      rsp_lo_in    = rsp_lo_ff;
      rsp_hi_in    = rsp_hi_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      srt_we       = 1'b0;
      srt_waddr    = '0;
      srt_wdata    = sample_ff;
      srt_raddr    = '0;
      ring_we      = 1'b0;
      ring_waddr   = ptr_ff;
      ring_wdata   = sample_ff;
      ring_raddr   = ptr_ff;

      unique case (cmd.op)
         swm_pkg::OP_NONE: begin
         end
         swm_pkg::OP_TAKE: begin
            sample_in = req_sample & swm_pkg::SAMPLE_MASK;
            scan_in   = '0;
            found_in  = 1'b0;
            pos_in    = full ? swm_pkg::CNT_BITS'(swm_pkg::WINDOW - 1) : fill_ff;
         end
         swm_pkg::OP_MED_LO: begin
            srt_raddr  = swm_pkg::IDX_BITS'(swm_pkg::HALF_LO);
            ring_raddr = ptr_ff;
         end
         swm_pkg::OP_MED_HI: begin
            srt_raddr = swm_pkg::IDX_BITS'(swm_pkg::HALF_HI);
            lo_in     = srt_rdata;
            oldest_in = ring_rdata;
         end
         swm_pkg::OP_MED_END: begin
            hi_in = srt_rdata;
         end
         swm_pkg::OP_REMOVE: begin
            // Read runs one entry ahead; once the oldest value has been
            // matched, every later entry moves down by one place.
            srt_raddr = scan_ff[swm_pkg::IDX_BITS-1:0];
            scan_in   = scan_ff + swm_pkg::CNT_BITS'(1);
            if (scan_ff != '0) begin
               if (found_ff) begin
                  srt_we    = 1'b1;
                  srt_waddr = scan_m2[swm_pkg::IDX_BITS-1:0];
                  srt_wdata = srt_rdata;
               end else if (srt_rdata == oldest_ff) begin
                  found_in = 1'b1;
               end
            end
         end
         swm_pkg::OP_INS_RD: begin
            if (pos_ff == '0) begin
               srt_we    = 1'b1;
               srt_waddr = '0;
               srt_wdata = sample_ff;
            end else begin
               srt_raddr = pos_m1[swm_pkg::IDX_BITS-1:0];
            end
         end
         swm_pkg::OP_INS_CMP: begin
            srt_we    = 1'b1;
            srt_waddr = pos_ff[swm_pkg::IDX_BITS-1:0];
            if (srt_rdata > sample_ff) begin
               // Shift the larger entry up and fetch the next one below.
               srt_wdata = srt_rdata;
               pos_in    = pos_m1;
               srt_raddr = pos_m2[swm_pkg::IDX_BITS-1:0];
            end else begin
               srt_wdata = sample_ff;
            end
         end
         swm_pkg::OP_FINISH: begin
            ring_we    = 1'b1;
            ring_waddr = ptr_ff;
            ring_wdata = sample_ff;
            if (ptr_ff == swm_pkg::IDX_BITS'(swm_pkg::WINDOW - 1)) begin
               ptr_in = '0;
            end else begin
               ptr_in = ptr_ff + swm_pkg::IDX_BITS'(1);
            end
            if (!full) begin
               fill_in = fill_ff + swm_pkg::CNT_BITS'(1);
            end
         end
         swm_pkg::OP_EMIT: begin
            rsp_lo_in    = lo_ff;
            rsp_hi_in    = hi_ff;
            rsp_sum_in   = {1'b0, lo_ff} + {1'b0, hi_ff};
            rsp_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_lower_middle = rsp_lo_ff;
   assign rsp_upper_middle = rsp_hi_ff;
   assign rsp_middle_sum   = rsp_sum_ff;

   a_ptr_tracks_fill: assert property (@(posedge clock) disable iff (reset)
      !full |-> (ptr_ff == fill_ff[swm_pkg::IDX_BITS-1:0]))
      else $error("ring pointer does not track fill count while filling");

   a_oldest_found: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == swm_pkg::OP_REMOVE && status.scan_done)
         |-> (found_ff || srt_rdata == oldest_ff))
      else $error("oldest sample missing from sorted window");

   a_emit_when_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == swm_pkg::OP_EMIT) |-> (full && status.out_free))
      else $error("result loaded while window not full or output busy");

   a_insert_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == swm_pkg::OP_INS_RD || cmd.op == swm_pkg::OP_INS_CMP)
         |-> (pos_ff <= swm_pkg::CNT_BITS'(swm_pkg::WINDOW - 1)))
      else $error("insert position beyond sorted window");

endmodule
`default_nettype wire

### sv/sliding_window_median.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_median: running median over the last WINDOW samples
// Samples enter on the req_ channel. Each sample that arrives with a full
// window yields the two middle values of the window as it stood before it
// and their sum on the rsp_ channel; the oldest sample leaves and the new
// one is inserted, and the result is loaded once that is done. The first
// WINDOW samples only fill the window and produce no transfer on rsp_.
// One sample is handled at a time; req_stall is high while it is in work.
// The work is set by passes over the sorted window RAM: while filling, a
// sample needs only an insertion walk and ring update; with a full window
// it needs a removal scan over the whole window plus an insertion walk
// that depends on where the new sample lands.
// The result sits in an output register; if the receiver holds rsp_stall,
// the result waits there and the block stalls only once the next result
// is ready to be loaded. Reset empties the window and drops any pending
// result; the RAM contents need no clearing, since the fill count guards
// every read.
// ----------------------------------------------------------------------------
module sliding_window_median (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [swm_pkg::SAMPLE_W-1:0] req_sample,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic      [swm_pkg::SAMPLE_W-1:0] rsp_lower_middle,
   output logic      [swm_pkg::SAMPLE_W-1:0] rsp_upper_middle,
   output logic      [swm_pkg::SUM_W-1:0]    rsp_middle_sum
);

   // Command and status between the sequencer and the datapath.
   swm_pkg::cmd_type    cmd;
   swm_pkg::status_type status;

   // The controller walks each sample through its steps: with a full window,
   // median read and removal of the oldest sample; then insertion of the new
   // one, ring update and, with a full window, loading of the output register.
   swm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the two RAMs, the counters and the output register.
   swm_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_sample       (req_sample),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_lower_middle (rsp_lower_middle),
      .rsp_upper_middle (rsp_upper_middle),
      .rsp_middle_sum   (rsp_middle_sum)
   );

endmodule
`default_nettype wire
